// File: hw/rtl/mste_pkg.sv
// Shared types and constants for the minimum spanning tree engine.
// No dependencies; imported by the cell modules and the top level.
package mste_pkg;

    localparam int VTX_BITS = 5;   // endpoint field width on the ports
    localparam int SUM_BITS = 21;  // running total width, wraps
    localparam int MAX_TREE = 31;  // tree edges reported per run at most

    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH,
        S_LOOK,
        S_JOIN,
        S_TOTAL
    } t_state;

    typedef struct packed {
        logic ins;   // insert the arriving edge in weight order
        logic pop;   // shift the chain one place toward the head
    } t_sort_ctl;

    typedef struct packed {
        logic clear;    // every vertex back to its own tree
        logic relabel;  // move one tree's vertices into another
    } t_vtx_ctl;

endpackage

// File: hw/rtl/mste_sort_cell.sv
// One cell of the insertion-sort chain holding a stored edge {u, v, weight}.
// Depends on mste_pkg for the control struct.
module mste_sort_cell #(
    parameter int WEIGHT_BITS = 16
) (
    input  logic                  i_clk,
    input  mste_pkg::t_sort_ctl   i_ctl,
    input  logic                  i_occ,
    input  logic                  i_prev_keep,
    input  logic [WEIGHT_BITS+9:0] i_new,
    input  logic [WEIGHT_BITS+9:0] i_prev,
    input  logic [WEIGHT_BITS+9:0] i_next,
    output logic [WEIGHT_BITS+9:0] o_edge,
    output logic                  o_keep
);
    import mste_pkg::*;

    logic [WEIGHT_BITS+9:0] r_edge;
    logic [WEIGHT_BITS+9:0] n_edge;

    // equal weights stay ahead of the newcomer, so arrival order holds
    assign o_keep = i_occ &&
        ($signed(r_edge[WEIGHT_BITS-1:0]) <= $signed(i_new[WEIGHT_BITS-1:0]));
    assign o_edge = r_edge;

    always_comb begin
        n_edge = r_edge;
        if (i_ctl.pop) begin
            n_edge = i_next;
        end else if (i_ctl.ins && !o_keep) begin
            n_edge = i_prev_keep ? i_new : i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_edge <= n_edge;
    end

endmodule

// File: hw/rtl/mste_vertex_cell.sv
// One vertex cell: holds the tree label of its vertex for the connectivity check.
// Depends on mste_pkg for the control struct.
module mste_vertex_cell #(
    parameter int LABEL_BITS = 5,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mste_pkg::t_vtx_ctl    i_ctl,
    input  logic [LABEL_BITS-1:0] i_from,
    input  logic [LABEL_BITS-1:0] i_to,
    output logic [LABEL_BITS-1:0] o_label
);
    import mste_pkg::*;

    logic [LABEL_BITS-1:0] r_label;
    logic [LABEL_BITS-1:0] n_label;

    assign o_label = r_label;

    always_comb begin
        n_label = r_label;
        if (i_ctl.clear) begin
            n_label = LABEL_BITS'(INDEX);
        end else if (i_ctl.relabel && r_label == i_from) begin
            n_label = i_to;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label <= LABEL_BITS'(INDEX);
        end else begin
            r_label <= n_label;
        end
    end

endmodule

// File: hw/rtl/minimum_spanning_tree_engine.sv
// Minimum spanning tree engine, top level. Uses mste_pkg, mste_sort_cell and
// mste_vertex_cell.
//
// Edges stream in at one per cycle while the block is loading and are inserted
// straight into a chain of sort cells, so the chain is always in ascending weight
// order (equal weights in arrival order). The edge marked tlast starts the tree
// pass: each stored edge is popped from the chain head, both endpoint labels are
// looked up in the vertex cells, and, for in-range endpoints in different trees,
// the two trees are joined by relabeling every matching vertex cell at once; a
// join stalls whenever the output register is still full. The total result
// follows, after which the block takes edges again. No clearing pass is needed
// after reset.
module minimum_spanning_tree_engine #(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_EDGES    = 256,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [mste_pkg::VTX_BITS-1:0]         i_cfg_wdata, // max_vertex_index
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // edge_u, edge_v, edge_weight from bit 0 up, zero padded to bytes
    input  logic [((2*mste_pkg::VTX_BITS+WEIGHT_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                                  s_axis_tlast,  // last_edge
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tree_u, tree_v, tree_weight, total_weight, dropped_edges from bit 0 up
    output logic [((2*mste_pkg::VTX_BITS+WEIGHT_BITS+mste_pkg::SUM_BITS+1+7)/8)*8-1:0]
                                                  m_axis_tdata,
    output logic                                  m_axis_tuser,  // result_kind
    output logic                                  m_axis_tlast   // last_result
);
    import mste_pkg::*;

    localparam int EW  = 2 * VTX_BITS + WEIGHT_BITS;
    localparam int IW  = ((EW + 7) / 8) * 8;
    localparam int OW  = ((EW + SUM_BITS + 1 + 7) / 8) * 8;
    localparam int CW  = $clog2(MAX_EDGES + 1);
    localparam int LW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int KW  = $clog2(MAX_TREE + 1);

    t_state r_state, n_state;

    logic [VTX_BITS-1:0] r_max_vi;
    logic [CW-1:0]       r_count;
    logic                r_dropped;
    logic [SUM_BITS-1:0] r_sum;
    logic [KW-1:0]       r_k;
    logic [EW-1:0]       r_cur;
    logic [LW-1:0]       r_la, r_lb;

    logic                r_ovalid;
    logic                r_okind, r_olast, r_odrop;
    logic [VTX_BITS-1:0] r_ou, r_ov;
    logic [WEIGHT_BITS-1:0] r_ow;
    logic [SUM_BITS-1:0] r_osum;

    // limit = min(max_vertex_index, MAX_VERTICES-1), one bit wider for 64 vertices
    logic [VTX_BITS:0] lim;
    assign lim = ({1'b0, r_max_vi} > (VTX_BITS+1)'(MAX_VERTICES - 1)) ?
                 (VTX_BITS+1)'(MAX_VERTICES - 1) : {1'b0, r_max_vi};

    logic [EW-1:0]       new_edge;
    logic [VTX_BITS-1:0] in_u, in_v, cur_u, cur_v;
    logic                in_ok, cur_ok, s_acc, out_free, do_join;
    logic [SUM_BITS-1:0] sum_next;

    assign in_u     = s_axis_tdata[VTX_BITS-1:0];
    assign in_v     = s_axis_tdata[2*VTX_BITS-1:VTX_BITS];
    assign new_edge = {in_u, in_v, s_axis_tdata[EW-1:2*VTX_BITS]};
    assign in_ok    = {1'b0, in_u} <= lim && {1'b0, in_v} <= lim;
    assign cur_u    = r_cur[EW-1:EW-VTX_BITS];
    assign cur_v    = r_cur[EW-VTX_BITS-1:WEIGHT_BITS];
    assign cur_ok   = {1'b0, cur_u} <= lim && {1'b0, cur_v} <= lim;
    assign out_free = !r_ovalid || m_axis_tready;
    assign do_join  = (r_la != r_lb) && (r_k != KW'(MAX_TREE));
    assign sum_next = r_sum + SUM_BITS'($signed(r_cur[WEIGHT_BITS-1:0]));

    // control outputs of the sequencer
    t_sort_ctl sort_ctl;
    t_vtx_ctl  vtx_ctl;
    logic      ld_tree, ld_total, latch_cur, latch_lab, mark_drop;

    assign s_axis_tready = (r_state == S_LOAD);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    // sort chain
    logic [EW-1:0]        cell_edge [MAX_EDGES];
    logic [MAX_EDGES-1:0] cell_keep;

    for (genvar i = 0; i < MAX_EDGES; i++) begin : g_sort
        logic [EW-1:0] prev_e, next_e;
        logic          prev_k;
        if (i == 0) begin : g_head
            assign prev_e = new_edge;
            assign prev_k = 1'b1;
        end else begin : g_body
            assign prev_e = cell_edge[i-1];
            assign prev_k = cell_keep[i-1];
        end
        if (i == MAX_EDGES - 1) begin : g_tail
            assign next_e = cell_edge[i];
        end else begin : g_mid
            assign next_e = cell_edge[i+1];
        end
        mste_sort_cell #(.WEIGHT_BITS(WEIGHT_BITS)) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (sort_ctl),
            .i_occ       (CW'(i) < r_count),
            .i_prev_keep (prev_k),
            .i_new       (new_edge),
            .i_prev      (prev_e),
            .i_next      (next_e),
            .o_edge      (cell_edge[i]),
            .o_keep      (cell_keep[i])
        );
    end

    // vertex label cells
    logic [LW-1:0] vtx_label [MAX_VERTICES];

    for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_vtx
        mste_vertex_cell #(.LABEL_BITS(LW), .INDEX(i)) u_vtx (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (vtx_ctl),
            .i_from  (r_lb),
            .i_to    (r_la),
            .o_label (vtx_label[i])
        );
    end

    logic [LW-1:0] look_u, look_v;
    always_comb begin
        look_u = '0;
        look_v = '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            if ({1'b0, cur_u} == (VTX_BITS+1)'(i)) look_u = look_u | vtx_label[i];
            if ({1'b0, cur_v} == (VTX_BITS+1)'(i)) look_v = look_v | vtx_label[i];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:  if (s_acc && s_axis_tlast) n_state = S_FETCH;
            S_FETCH: n_state = (r_count == '0) ? S_TOTAL : S_LOOK;
            S_LOOK:  n_state = cur_ok ? S_JOIN : S_FETCH;
            S_JOIN:  if (!do_join || out_free) n_state = S_FETCH;
            S_TOTAL: if (out_free) n_state = S_LOAD;
            default: n_state = S_LOAD;
        endcase
    end

    // sequencer outputs
    always_comb begin
        sort_ctl  = '0;
        vtx_ctl   = '0;
        ld_tree   = 1'b0;
        ld_total  = 1'b0;
        latch_cur = 1'b0;
        latch_lab = 1'b0;
        mark_drop = 1'b0;
        case (r_state)
            S_LOAD: begin
                sort_ctl.ins = s_acc && in_ok && (r_count != CW'(MAX_EDGES));
                mark_drop    = s_acc && !(in_ok && (r_count != CW'(MAX_EDGES)));
            end
            S_FETCH: begin
                latch_cur    = (r_count != '0);
                sort_ctl.pop = (r_count != '0);
            end
            S_LOOK: begin
                latch_lab = cur_ok;
                mark_drop = !cur_ok;
            end
            S_JOIN: begin
                ld_tree         = do_join && out_free;
                vtx_ctl.relabel = do_join && out_free;
            end
            S_TOTAL: begin
                ld_total      = out_free;
                vtx_ctl.clear = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_max_vi  <= VTX_BITS'(31);
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_sum     <= '0;
            r_k       <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_max_vi <= i_cfg_wdata;
            if (sort_ctl.ins) r_count <= r_count + CW'(1);
            if (sort_ctl.pop) r_count <= r_count - CW'(1);
            if (mark_drop) r_dropped <= 1'b1;
            if (ld_tree) begin
                r_sum <= sum_next;
                r_k   <= r_k + KW'(1);
            end
            if (ld_total) begin
                r_dropped <= 1'b0;
                r_sum     <= '0;
                r_k       <= '0;
            end
            if (ld_tree || ld_total) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (latch_cur) r_cur <= cell_edge[0];
        if (latch_lab) begin
            r_la <= look_u;
            r_lb <= look_v;
        end
        if (ld_tree) begin
            r_okind <= 1'b0;
            r_olast <= 1'b0;
            r_ou    <= cur_u;
            r_ov    <= cur_v;
            r_ow    <= r_cur[WEIGHT_BITS-1:0];
            r_osum  <= sum_next;
            r_odrop <= r_dropped;
        end else if (ld_total) begin
            r_okind <= 1'b1;
            r_olast <= 1'b1;
            r_ou    <= '0;
            r_ov    <= '0;
            r_ow    <= '0;
            r_osum  <= r_sum;
            r_odrop <= r_dropped;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OW'({r_odrop, r_osum, r_ow, r_ov, r_ou});
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

    logic unused_pad;
    assign unused_pad = ^s_axis_tdata[IW-1:EW];

    // the store never holds more than its capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_EDGES)) else $error("edge count beyond capacity");

    // a pending tree result always has been counted
    a_tree_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !r_okind |-> r_k != '0) else $error("tree result not counted");

    // total result and end marker travel together
    a_kind_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_okind == r_olast) else $error("kind and last disagree");

    // the chain is drained before a total result is produced
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_total |-> r_count == '0) else $error("total with edges left");

endmodule

// File: bench/tb_minimum_spanning_tree_engine.sv
// Self-checking bench for the minimum spanning tree engine: a scoreboard class
// predicts tree edges and totals for every graph; plain tasks drive the streams.
// Depends on mste_pkg and the minimum_spanning_tree_engine RTL.
module tb_minimum_spanning_tree_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NVTX      = 32;
    localparam int EDGE_CAP  = 256;
    localparam int WDOG_MAX  = 20000;
    localparam bit KIND_EDGE  = 1'b0;
    localparam bit KIND_TOTAL = 1'b1;

    typedef struct {
        logic [4:0]         u;
        logic [4:0]         v;
        logic signed [15:0] w;
    } t_edge;

    typedef struct {
        logic               kind;
        logic [4:0]         u;
        logic [4:0]         v;
        logic signed [15:0] w;
        logic [20:0]        total;
        logic               dropped;
        logic               last;
    } t_tree_result;

    class mst_scoreboard;
        t_edge        graph_edges[$];
        t_tree_result tree_results[$];
        logic [4:0]   vtx_limit;
        bit           drop_seen;
        int           mismatches;
        int           checked;
        int           graphs;
        int           parent[NVTX];
        int           rank_of[NVTX];

        function new();
            vtx_limit  = 5'd31;
            drop_seen  = 0;
            mismatches = 0;
            checked    = 0;
            graphs     = 0;
        endfunction

        function int root_of(int x);
            int r;
            int nx;
            r = x;
            while (parent[r] != r) r = parent[r];
            while (x != r) begin
                nx = parent[x];
                parent[x] = r;
                x = nx;
            end
            return r;
        endfunction

        function void build_tree();
            t_edge        sorted[$];
            t_edge        e;
            t_tree_result res;
            logic [20:0]  sum;
            int           j;
            int           ra;
            int           rb;
            int           picked;
            // stable insertion sort: equal weights keep arrival order
            foreach (graph_edges[i]) begin
                e = graph_edges[i];
                j = sorted.size();
                while (j > 0 && sorted[j-1].w > e.w) j--;
                sorted.insert(j, e);
            end
            for (int i = 0; i < NVTX; i++) begin
                parent[i]  = i;
                rank_of[i] = 0;
            end
            sum = '0;
            picked = 0;
            foreach (sorted[i]) begin
                e = sorted[i];
                if (e.u > vtx_limit || e.v > vtx_limit) begin
                    drop_seen = 1;
                    continue;
                end
                ra = root_of(e.u);
                rb = root_of(e.v);
                if (ra != rb && picked < mste_pkg::MAX_TREE) begin
                    sum = sum + 21'(e.w);
                    if (rank_of[ra] < rank_of[rb]) parent[ra] = rb;
                    else if (rank_of[ra] > rank_of[rb]) parent[rb] = ra;
                    else begin
                        parent[rb] = ra;
                        if (rank_of[ra] < 7) rank_of[ra]++;
                    end
                    res = '{KIND_EDGE, e.u, e.v, e.w, sum, drop_seen, 1'b0};
                    tree_results.insert(tree_results.size(), res);
                    picked++;
                end
            end
            res = '{KIND_TOTAL, 5'd0, 5'd0, 16'sd0, sum, drop_seen, 1'b1};
            tree_results.insert(tree_results.size(), res);
            graph_edges.delete();
            drop_seen = 0;
            graphs++;
        endfunction

        function void note_edge(logic [4:0] u, logic [4:0] v, logic signed [15:0] w,
                                logic last);
            t_edge e;
            if (u > vtx_limit || v > vtx_limit || graph_edges.size() >= EDGE_CAP) begin
                drop_seen = 1;
            end else begin
                e = '{u, v, w};
                graph_edges.insert(graph_edges.size(), e);
            end
            if (last) build_tree();
        endfunction

        function void cmp(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_result(t_tree_result act);
            t_tree_result exp_r;
            if (tree_results.size() == 0) begin
                $error("unexpected result transaction: kind %0d u %0d v %0d", act.kind,
                       act.u, act.v);
                mismatches++;
                return;
            end
            exp_r = tree_results.pop_front();
            checked++;
            cmp("result_kind", exp_r.kind, act.kind);
            cmp("tree_u", exp_r.u, act.u);
            cmp("tree_v", exp_r.v, act.v);
            cmp("tree_weight", exp_r.w, act.w);
            cmp("total_weight", $signed(exp_r.total), $signed(act.total));
            cmp("dropped_edges", exp_r.dropped, act.dropped);
            cmp("last_result", exp_r.last, act.last);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [4:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // edge_u, edge_v, edge_weight, zero pad
    logic        s_axis_tlast;   // last_edge
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // tree_u, tree_v, tree_weight, total_weight, dropped
    logic        m_axis_tuser;   // result_kind
    logic        m_axis_tlast;   // last_result

    mst_scoreboard sb;
    int          idle_cycles;
    int          edges_sent;
    int          stall_hold;
    bit          stall_on;
    int          cfg_writes;

    minimum_spanning_tree_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // receiver backpressure: mostly short stalls, some long, with calm stretches
    always @(negedge i_clk) begin
        if ($urandom_range(0, 299) == 0) stall_on = ~stall_on;
        if (stall_hold > 0) begin
            stall_hold--;
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = 1'b1;
            if (stall_on) begin
                case ($urandom_range(0, 99)) inside
                    [0:19]: stall_hold = $urandom_range(1, 3);
                    [20:21]: stall_hold = $urandom_range(10, 40);
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_tree_result act;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            act.u       = m_axis_tdata[4:0];
            act.v       = m_axis_tdata[9:5];
            act.w       = m_axis_tdata[25:10];
            act.total   = m_axis_tdata[46:26];
            act.dropped = m_axis_tdata[47];
            act.kind    = m_axis_tuser;
            act.last    = m_axis_tlast;
            sb.check_result(act);
        end
    end

    // watchdog: count cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else if (i_rst_n) begin
            idle_cycles++;
            if (idle_cycles >= WDOG_MAX) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_edge(logic [4:0] u, logic [4:0] v, logic signed [15:0] w,
                             logic last);
        int gap;
        case ($urandom_range(0, 19)) inside
            [0:9]: gap = 0;
            [10:18]: gap = $urandom_range(1, 3);
            default: gap = $urandom_range(8, 30);
        endcase
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {6'd0, w, v, u};
        s_axis_tlast  = last;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_edge(u, v, w, last);
        edges_sent++;
    endtask

    // hold off until every pending result is out, then let the engine settle
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.tree_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [4:0] lim);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = lim;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.vtx_limit = lim;
        cfg_writes++;
    endtask

    function automatic logic signed [15:0] pick_weight();
        case ($urandom_range(0, 9)) inside
            [0:4]: return 16'($signed($urandom_range(0, 12)) - 6);
            5: return 16'sh8000;
            6: return 16'sh7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_graph(int n_edges);
        logic [4:0] u;
        logic [4:0] v;
        for (int i = 0; i < n_edges; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                u = 5'($urandom);
                v = 5'($urandom);
            end else begin
                u = 5'($urandom_range(0, sb.vtx_limit));
                v = 5'($urandom_range(0, sb.vtx_limit));
            end
            send_edge(u, v, pick_weight(), i == n_edges - 1);
        end
    endtask

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b1;
        idle_cycles   = 0;
        edges_sent    = 0;
        stall_hold    = 0;
        stall_on      = 1'b1;
        cfg_writes    = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // extremes, weight ties, self loop and duplicate edge at full range
        send_edge(5'd31, 5'd0, 16'sh8000, 1'b0);
        send_edge(5'd0, 5'd31, 16'sh7fff, 1'b0);
        send_edge(5'd1, 5'd2, 16'sd5, 1'b0);
        send_edge(5'd3, 5'd4, 16'sd5, 1'b0);
        send_edge(5'd2, 5'd1, 16'sd5, 1'b0);
        send_edge(5'd7, 5'd7, -16'sd5, 1'b0);
        send_edge(5'd31, 5'd0, 16'sd5, 1'b0);
        send_edge(5'd5, 5'd6, 16'sd0, 1'b1);
        // endpoint beyond the limit on input
        write_limit(5'd7);
        send_edge(5'd8, 5'd1, 16'sd3, 1'b0);
        send_edge(5'd0, 5'd7, -16'sd2, 1'b0);
        send_edge(5'd1, 5'd31, 16'sd1, 1'b1);
        // limit lowered after edges are stored
        write_limit(5'd31);
        send_edge(5'd20, 5'd21, 16'sd1, 1'b0);
        send_edge(5'd1, 5'd2, 16'sd2, 1'b0);
        write_limit(5'd15);
        send_edge(5'd3, 5'd4, 16'sd4, 1'b1);
        // no usable edge: only the total comes back
        write_limit(5'd0);
        send_edge(5'd1, 5'd0, 16'sd9, 1'b1);
        send_edge(5'd0, 5'd0, -16'sd9, 1'b1);
        write_limit(5'd31);

        // random graphs under several limits, pausing for a drain now and then
        while (edges_sent < 100) begin
            case ($urandom_range(0, 5))
                0: write_limit(5'd31);
                1: write_limit(5'd0);
                2: write_limit(5'($urandom));
                default: if ($urandom_range(0, 3) == 0) drain();
            endcase
            random_graph($urandom_range(1, 14));
        end

        drain();
        $display("covered %0d edges in %0d graphs, %0d results checked, %0d limit writes",
                 edges_sent, sb.graphs, sb.checked, cfg_writes);
        if (sb.mismatches == 0 && sb.tree_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results outstanding", sb.mismatches,
                     sb.tree_results.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
